@@ rtl/inertial_to_radial_track_cross_rotation_macros.svh @@
// Assertion macros used by the RTL of the rotation block.
`ifndef INERTIAL_TO_RADIAL_TRACK_CROSS_ROTATION_MACROS_SVH
`define INERTIAL_TO_RADIAL_TRACK_CROSS_ROTATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ITR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/itr_pkg.sv @@
package itr_pkg;

   localparam int IN_WIDTH  = 24;
   localparam int FRAC_BITS = 14;
   localparam int OUT_WIDTH = 16;

   localparam int W   = IN_WIDTH;
   localparam int PSW = 2 * IN_WIDTH;
   localparam int HW  = 2 * IN_WIDTH + 1;
   localparam int HSW = 4 * IN_WIDTH;
   localparam int TW  = 3 * IN_WIDTH + 1;
   localparam int TXW = 3 * IN_WIDTH + 2;
   localparam int SW  = 6 * IN_WIDTH;

   localparam int QB  = 2 * FRAC_BITS + 3;
   localparam int RB  = FRAC_BITS + 2;
   localparam int SQW = 2 * RB;

   localparam int OUT_MAX = (2 ** FRAC_BITS < 2 ** (OUT_WIDTH - 1) - 1) ?
                            2 ** FRAC_BITS : 2 ** (OUT_WIDTH - 1) - 1;

   localparam int NUM_LANES   = 9;
   localparam int FRONT_DEPTH = 7;
   localparam int LANE_DEPTH  = QB + RB + 1;
   localparam int TOTAL_DEPTH = FRONT_DEPTH + LANE_DEPTH;

   localparam int IN_TDATA_W  = ((6 * IN_WIDTH + 7) / 8) * 8;
   localparam int OUT_TDATA_W = ((NUM_LANES * OUT_WIDTH + 7) / 8) * 8;

   typedef struct packed {
      logic [SW-1:0] a2;
      logic [SW-1:0] s;
      logic          neg;
   } itr_lane_in_type;

endpackage

@@ rtl/itr_lane.sv @@
module itr_lane import itr_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  itr_lane_in_type      lane_in,
   output logic [OUT_WIDTH-1:0] lane_out
);

   function automatic logic [SW:0] div_step(input logic [SW-1:0] r, input logic [SW-1:0] s);
      logic [SW:0] tr;
      logic [SW:0] df;
      tr = {r, 1'b0};
      df = tr - {1'b0, s};
      if (tr >= {1'b0, s}) begin
         div_step = {1'b1, df[SW-1:0]};
      end else begin
         div_step = {1'b0, tr[SW-1:0]};
      end
   endfunction

   function automatic logic [RB-1:0] sqrt_step(input logic [RB-1:0] r, input logic [QB-1:0] q,
                                               input int b);
      logic [RB-1:0]  c;
      logic [SQW-1:0] sq;
      c  = r | (RB'(1) << b);
      sq = SQW'(c) * SQW'(c);
      sqrt_step = (sq <= SQW'(q)) ? c : r;
   endfunction

   logic [SW-1:0]        dr_ff [QB-1];
   logic [SW-1:0]        dr_in [QB-1];
   logic [SW-1:0]        ds_ff [QB-1];
   logic [SW-1:0]        ds_in [QB-1];
   logic [QB-1:0]        dq_ff [QB-1];
   logic [QB-1:0]        dq_in [QB-1];
   logic                 dn_ff [QB-1];
   logic                 dn_in [QB-1];
   logic [QB-1:0]        fq_ff, fq_in;
   logic                 fn_ff, fn_in;
   logic [QB-1:0]        sq_ff [RB-1];
   logic [QB-1:0]        sq_in [RB-1];
   logic [RB-1:0]        sr_ff [RB];
   logic [RB-1:0]        sr_in [RB];
   logic                 sn_ff [RB];
   logic                 sn_in [RB];
   logic [OUT_WIDTH-1:0] out_ff, out_in;

   always_comb begin
      logic [SW:0]          st;
      logic [RB:0]          rp;
      logic [RB-1:0]        lo;
      logic [OUT_WIDTH-1:0] mag;
      dq_in[0] = QB'(lane_in.a2 >= lane_in.s);
      dr_in[0] = (lane_in.a2 >= lane_in.s) ? lane_in.a2 - lane_in.s : lane_in.a2;
      ds_in[0] = lane_in.s;
      dn_in[0] = lane_in.neg;
      for (int k = 1; k < QB - 1; k++) begin
         st       = div_step(dr_ff[k-1], ds_ff[k-1]);
         dr_in[k] = st[SW-1:0];
         dq_in[k] = {dq_ff[k-1][QB-2:0], st[SW]};
         ds_in[k] = ds_ff[k-1];
         dn_in[k] = dn_ff[k-1];
      end
      st    = div_step(dr_ff[QB-2], ds_ff[QB-2]);
      fq_in = {dq_ff[QB-2][QB-2:0], st[SW]};
      fn_in = dn_ff[QB-2];

      sr_in[0] = sqrt_step('0, fq_ff, RB - 1);
      sq_in[0] = fq_ff;
      sn_in[0] = fn_ff;
      for (int j = 1; j < RB - 1; j++) begin
         sr_in[j] = sqrt_step(sr_ff[j-1], sq_ff[j-1], RB - 1 - j);
         sq_in[j] = sq_ff[j-1];
         sn_in[j] = sn_ff[j-1];
      end
      sr_in[RB-1] = sqrt_step(sr_ff[RB-2], sq_ff[RB-2], 0);
      sn_in[RB-1] = sn_ff[RB-2];

      rp = {1'b0, sr_ff[RB-1]} + 1'b1;
      lo = rp[RB:1];
      if (lo > RB'(OUT_MAX)) begin
         lo = RB'(OUT_MAX);
      end
      mag    = OUT_WIDTH'(lo);
      out_in = sn_ff[RB-1] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dr_ff  <= dr_in;
         ds_ff  <= ds_in;
         dq_ff  <= dq_in;
         dn_ff  <= dn_in;
         fq_ff  <= fq_in;
         fn_ff  <= fn_in;
         sq_ff  <= sq_in;
         sr_ff  <= sr_in;
         sn_ff  <= sn_in;
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

@@ rtl/inertial_to_radial_track_cross_rotation.sv @@
// Pipeline from input transfer to output, in order:
// seven cross-product and norm stages, 2*FRAC_BITS+3 divider stages, FRAC_BITS+2
// square-root stages, one rounding stage and the output register.
// Throughput: one item per cycle; the pipeline advances while its skid register is empty.
// Reset clears the pipeline valid bits and the output and skid valid flags; data is not reset.
`include "inertial_to_radial_track_cross_rotation_macros.svh"

module inertial_to_radial_track_cross_rotation import itr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   // degenerate
   output logic                   rsp_tuser
);

   logic en;

   logic signed [W-1:0]   vin [3];
   logic signed [W-1:0]   p1_ff [3], p1_in [3];
   logic signed [PSW-1:0] a1_ff [3], a1_in [3];
   logic signed [PSW-1:0] b1_ff [3], b1_in [3];

   logic signed [HW-1:0]  h2_ff [3], h2_in [3];
   logic signed [W-1:0]   p2_ff [3];

   logic signed [W:0]     hh [3];
   logic signed [W:0]     hl [3];
   logic [HW-1:0]         habs [3];
   logic signed [HW-1:0]  c3_ff [3], c3_in [3];
   logic signed [HW-1:0]  d3_ff [3], d3_in [3];
   logic signed [HW-1:0]  e3_ff [3], e3_in [3];
   logic signed [HW-1:0]  f3_ff [3], f3_in [3];
   logic [PSW-1:0]        psq3_ff [3], psq3_in [3];
   logic [PSW-1:0]        hll3_ff [3], hll3_in [3];
   logic [PSW-1:0]        hlh3_ff [3], hlh3_in [3];
   logic [PSW-1:0]        hhh3_ff [3], hhh3_in [3];
   logic                  hn3_ff [3], hn3_in [3];
   logic                  pn3_ff [3], pn3_in [3];
   logic                  hz3_in;

   logic signed [TXW-1:0] tx4 [3];
   logic signed [TW-1:0]  t4_ff [3], t4_in [3];
   logic [HSW-1:0]        hsq4 [3];
   logic [HSW-1:0]        sh4;
   logic [PSW-1:0]        sp4;
   itr_lane_in_type       ph4_ff [6], ph4_in [6];

   logic [TW-1:0]         tabs [3];
   logic [PSW-1:0]        tp5_ff [3][6], tp5_in [3][6];
   logic                  tn5_ff [3], tn5_in [3];
   itr_lane_in_type       ph5_ff [6];

   logic [SW-1:0]         tsq6_ff [3], tsq6_in [3];
   logic                  tn6_ff [3];
   itr_lane_in_type       ph6_ff [6];

   logic [SW-1:0]         st7;
   itr_lane_in_type       tl7_ff [3], tl7_in [3];
   itr_lane_in_type       ph7_ff [6];

   logic                  vld_ff [TOTAL_DEPTH], vld_in [TOTAL_DEPTH];
   logic                  dgn_ff [2:TOTAL_DEPTH-1], dgn_in [2:TOTAL_DEPTH-1];

   logic [OUT_WIDTH-1:0]  lane_out [NUM_LANES];
   logic [NUM_LANES*OUT_WIDTH-1:0] lanes_packed;

   logic                   push, take;
   logic [OUT_TDATA_W-1:0] new_data;
   logic                   out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic [OUT_TDATA_W-1:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;
   logic                   out_user_ff, out_user_in, skid_user_ff, skid_user_in;

   assign en         = !skid_vld_ff;
   assign req_tready = en;

   generate
      for (genvar i = 0; i < 3; i++) begin : g_comp
         localparam int J = (i + 1) % 3;
         localparam int K = (i + 2) % 3;

         assign p1_in[i] = req_tdata[i*W +: W];
         assign vin[i]   = req_tdata[(i+3)*W +: W];
         assign a1_in[i] = p1_in[J] * vin[K];
         assign b1_in[i] = p1_in[K] * vin[J];

         assign h2_in[i] = HW'(a1_ff[i]) - HW'(b1_ff[i]);

         assign hh[i]      = h2_ff[i][HW-1:W];
         assign hl[i]      = {1'b0, h2_ff[i][W-1:0]};
         assign habs[i]    = h2_ff[i][HW-1] ? -h2_ff[i] : h2_ff[i];
         assign c3_in[i]   = hh[J] * p2_ff[K];
         assign d3_in[i]   = hl[J] * p2_ff[K];
         assign e3_in[i]   = hh[K] * p2_ff[J];
         assign f3_in[i]   = hl[K] * p2_ff[J];
         assign psq3_in[i] = p2_ff[i] * p2_ff[i];
         assign hll3_in[i] = habs[i][W-1:0] * habs[i][W-1:0];
         assign hlh3_in[i] = habs[i][W-1:0] * habs[i][PSW-1:W];
         assign hhh3_in[i] = habs[i][PSW-1:W] * habs[i][PSW-1:W];
         assign hn3_in[i]  = h2_ff[i][HW-1];
         assign pn3_in[i]  = p2_ff[i][W-1];

         assign tx4[i]  = (TXW'(c3_ff[i]) <<< W) + TXW'(d3_ff[i])
                        - (TXW'(e3_ff[i]) <<< W) - TXW'(f3_ff[i]);
         assign t4_in[i] = tx4[i][TW-1:0];
         assign hsq4[i]  = (HSW'(hhh3_ff[i]) << PSW) + (HSW'(hlh3_ff[i]) << (W + 1))
                         + HSW'(hll3_ff[i]);
         assign ph4_in[i]     = '{a2: SW'(psq3_ff[i]), s: SW'(sp4), neg: pn3_ff[i]};
         assign ph4_in[3 + i] = '{a2: SW'(hsq4[i]), s: SW'(sh4), neg: hn3_ff[i]};

         assign tabs[i]      = t4_ff[i][TW-1] ? -t4_ff[i] : t4_ff[i];
         assign tp5_in[i][0] = tabs[i][0 +: W] * tabs[i][0 +: W];
         assign tp5_in[i][1] = tabs[i][0 +: W] * tabs[i][W +: W];
         assign tp5_in[i][2] = tabs[i][0 +: W] * tabs[i][2*W +: W];
         assign tp5_in[i][3] = tabs[i][W +: W] * tabs[i][W +: W];
         assign tp5_in[i][4] = tabs[i][W +: W] * tabs[i][2*W +: W];
         assign tp5_in[i][5] = tabs[i][2*W +: W] * tabs[i][2*W +: W];
         assign tn5_in[i]    = t4_ff[i][TW-1];

         assign tsq6_in[i] = SW'(tp5_ff[i][0]) + (SW'(tp5_ff[i][1]) << (W + 1))
                           + (SW'(tp5_ff[i][2]) << (2 * W + 1)) + (SW'(tp5_ff[i][3]) << (2 * W))
                           + (SW'(tp5_ff[i][4]) << (3 * W + 1)) + (SW'(tp5_ff[i][5]) << (4 * W));

         assign tl7_in[i] = '{a2: tsq6_ff[i], s: st7, neg: tn6_ff[i]};
      end
   endgenerate

   assign hz3_in = (h2_ff[0] == '0) && (h2_ff[1] == '0) && (h2_ff[2] == '0);
   assign sh4    = hsq4[0] + hsq4[1] + hsq4[2];
   assign sp4    = psq3_ff[0] + psq3_ff[1] + psq3_ff[2];
   assign st7    = tsq6_ff[0] + tsq6_ff[1] + tsq6_ff[2];

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= p1_in;
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         h2_ff   <= h2_in;
         p2_ff   <= p1_ff;
         c3_ff   <= c3_in;
         d3_ff   <= d3_in;
         e3_ff   <= e3_in;
         f3_ff   <= f3_in;
         psq3_ff <= psq3_in;
         hll3_ff <= hll3_in;
         hlh3_ff <= hlh3_in;
         hhh3_ff <= hhh3_in;
         hn3_ff  <= hn3_in;
         pn3_ff  <= pn3_in;
         t4_ff   <= t4_in;
         ph4_ff  <= ph4_in;
         tp5_ff  <= tp5_in;
         tn5_ff  <= tn5_in;
         ph5_ff  <= ph4_ff;
         tsq6_ff <= tsq6_in;
         tn6_ff  <= tn5_ff;
         ph6_ff  <= ph5_ff;
         tl7_ff  <= tl7_in;
         ph7_ff  <= ph6_ff;
         dgn_ff  <= dgn_in;
      end
   end

   always_comb begin
      vld_in[0] = req_tvalid;
      for (int k = 1; k < TOTAL_DEPTH; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
      dgn_in[2] = hz3_in;
      for (int k = 3; k < TOTAL_DEPTH; k++) begin
         dgn_in[k] = dgn_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   generate
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
         if (l < 3) begin : g_p
            itr_lane u_lane (.clock(clock), .en(en), .lane_in(ph7_ff[l]),
                             .lane_out(lane_out[l]));
         end else if (l < 6) begin : g_t
            itr_lane u_lane (.clock(clock), .en(en), .lane_in(tl7_ff[l-3]),
                             .lane_out(lane_out[l]));
         end else begin : g_h
            itr_lane u_lane (.clock(clock), .en(en), .lane_in(ph7_ff[l-3]),
                             .lane_out(lane_out[l]));
         end
         assign lanes_packed[l*OUT_WIDTH +: OUT_WIDTH] = lane_out[l];
      end
   endgenerate

   assign push     = en && vld_ff[TOTAL_DEPTH-1];
   assign take     = out_vld_ff && rsp_tready;
   assign new_data = dgn_ff[TOTAL_DEPTH-1] ? '0 : OUT_TDATA_W'(lanes_packed);

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      skid_user_in = skid_user_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_data_in = skid_data_ff;
            out_user_in = skid_user_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff || take) begin
            out_vld_in  = 1'b1;
            out_data_in = new_data;
            out_user_in = dgn_ff[TOTAL_DEPTH-1];
         end else begin
            skid_vld_in  = 1'b1;
            skid_data_in = new_data;
            skid_user_in = dgn_ff[TOTAL_DEPTH-1];
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_user_ff  <= out_user_in;
      skid_data_ff <= skid_data_in;
      skid_user_ff <= skid_user_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   `ITR_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_vld_ff, out_vld_ff, "skid holds data while output is empty")
   `ITR_ASSERT_NOW(a_degenerate_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "degenerate result carries a nonzero matrix")
   `ITR_ASSERT_NEXT(a_skid_catch, clock, reset, push && out_vld_ff && !rsp_tready, skid_vld_ff, "stalled result was not caught by the skid register")

endmodule
